// ----- rtl/core/i2cmbc_pkg.sv -----
// Package for the I2C master byte controller: command codes, item types
// and phase and reset constants. No dependencies.
package i2cmbc_pkg;

  // Command codes; the idle code marks no command in progress
  typedef enum logic [2:0] {
    OP_START = 3'd0,
    OP_STOP  = 3'd1,
    OP_WRITE = 3'd2,
    OP_WAIT  = 3'd3,
    OP_READ  = 3'd4,
    OP_IDLE  = 3'd7
  } op_e;

  localparam logic [7:0] PhaseTicksReset = 8'd5;

  // Phase counts per command
  localparam logic [4:0] StartPhases = 5'd3;
  localparam logic [4:0] StopPhases  = 5'd1;
  localparam logic [4:0] WritePhases = 5'd24;
  localparam logic [4:0] WaitPhases  = 5'd3;
  localparam logic [4:0] ReadPhases  = 5'd19;

  // Read phase markers: data bits end at ReadAckPhase
  localparam logic [4:0] ReadAckPhase  = 5'd16;
  localparam logic [4:0] ReadHighPhase = 5'd17;
  localparam logic [4:0] ReadLastPhase = 5'd18;

  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] operation;
    logic [7:0] tx_byte;
    logic       master_ack;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_drive_low;
    logic       sda_drive_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       slave_nack;
  } out_item_t;

endpackage

// ----- rtl/core/i2c_master_byte_controller.sv -----
// I2C master byte controller: one input item per tick, one result item per tick.
// A result is registered when its item is accepted and shown in the next cycle.
// Throughput: one item per cycle unless a result waits untaken; the output
// register is bypassed for ready when downstream takes it in the same cycle.
// Reset (rst_ni low, asynchronous): idle, lines released, phase_ticks 5,
// rx_byte 0, slave_nack 1, no result pending.
// Depends on i2cmbc_pkg.
module i2c_master_byte_controller (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [7:0]            cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  i2cmbc_pkg::in_item_t  in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output i2cmbc_pkg::out_item_t out_item_o
);

  // Line drives set on entry to a phase
  function automatic logic [1:0] enter_drive(
    i2cmbc_pkg::op_e op, logic [4:0] p, logic [1:0] sub, logic [2:0] bitn,
    logic [7:0] shift, logic mode, logic scl, logic sda);
    logic scl_n;
    logic sda_n;
    scl_n = scl;
    sda_n = sda;
    case (op)
      i2cmbc_pkg::OP_START: begin
        if (p == 5'd0) begin
          sda_n = 1'b0;
          scl_n = 1'b0;
        end else if (p == 5'd1) begin
          sda_n = 1'b1;
        end else begin
          scl_n = 1'b1;
        end
      end
      i2cmbc_pkg::OP_STOP: begin
        sda_n = 1'b1;
        scl_n = 1'b0;
      end
      i2cmbc_pkg::OP_WRITE: begin
        if (sub == 2'd0) begin
          sda_n = ~shift[7];
        end else if (sub == 2'd1) begin
          scl_n = 1'b0;
        end else begin
          scl_n = 1'b1;
          if (bitn == 3'd7) sda_n = 1'b0;
        end
      end
      i2cmbc_pkg::OP_WAIT: begin
        if (p == 5'd0) begin
          sda_n = 1'b0;
        end else if (p == 5'd1) begin
          scl_n = 1'b0;
        end else begin
          scl_n = 1'b1;
        end
      end
      i2cmbc_pkg::OP_READ: begin
        if (p < i2cmbc_pkg::ReadAckPhase) begin
          scl_n = p[0];
        end else if (p == i2cmbc_pkg::ReadAckPhase) begin
          sda_n = mode;
        end else if (p == i2cmbc_pkg::ReadHighPhase) begin
          scl_n = 1'b0;
        end else begin
          scl_n = 1'b1;
        end
      end
      default: begin
      end
    endcase
    return {scl_n, sda_n};
  endfunction

  function automatic logic [4:0] phase_total(i2cmbc_pkg::op_e op);
    logic [4:0] n;
    case (op)
      i2cmbc_pkg::OP_START: n = i2cmbc_pkg::StartPhases;
      i2cmbc_pkg::OP_STOP:  n = i2cmbc_pkg::StopPhases;
      i2cmbc_pkg::OP_WRITE: n = i2cmbc_pkg::WritePhases;
      i2cmbc_pkg::OP_WAIT:  n = i2cmbc_pkg::WaitPhases;
      i2cmbc_pkg::OP_READ:  n = i2cmbc_pkg::ReadPhases;
      default:              n = 5'd0;
    endcase
    return n;
  endfunction

  logic [7:0]            ticks_q;
  i2cmbc_pkg::op_e       op_q, op_d;
  logic [4:0]            phase_q, phase_d;
  logic [7:0]            tick_q, tick_d;
  logic [2:0]            bit_q, bit_d;
  logic [1:0]            sub_q, sub_d;
  logic [7:0]            shift_q, shift_d;
  logic                  scl_q, scl_d;
  logic                  sda_q, sda_d;
  logic                  ack_q, ack_d;
  logic                  mode_q, mode_d;
  logic [7:0]            rx_q, rx_d;
  logic                  done_d;
  logic [7:0]            limit;
  logic                  in_fire;
  logic                  out_valid_q;
  i2cmbc_pkg::out_item_t out_q, out_d;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = ~out_valid_q | out_ready_i;
  assign in_fire     = in_valid_i & in_ready_o;
  assign limit       = (ticks_q == 8'd0) ? 8'd1 : ticks_q;

  // Step the controller by one tick
  always_comb begin
    op_d    = op_q;
    phase_d = phase_q;
    tick_d  = tick_q;
    bit_d   = bit_q;
    sub_d   = sub_q;
    shift_d = shift_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    ack_d   = ack_q;
    mode_d  = mode_q;
    rx_d    = rx_q;
    done_d  = 1'b0;

    // Take a new command only when idle and the code is known
    if (op_q == i2cmbc_pkg::OP_IDLE && in_item_i.cmd_valid &&
        in_item_i.operation <= 3'(i2cmbc_pkg::OP_READ)) begin
      op_d    = i2cmbc_pkg::op_e'(in_item_i.operation);
      phase_d = 5'd0;
      tick_d  = 8'd0;
      bit_d   = 3'd0;
      sub_d   = 2'd0;
      if (op_d == i2cmbc_pkg::OP_WRITE) shift_d = in_item_i.tx_byte;
      if (op_d == i2cmbc_pkg::OP_READ) begin
        shift_d = 8'd0;
        mode_d  = in_item_i.master_ack;
      end
      {scl_d, sda_d} = enter_drive(op_d, phase_d, sub_d, bit_d, shift_d, mode_d,
                                   scl_d, sda_d);
    end

    // Count the tick and close the phase on its last tick
    if (op_d != i2cmbc_pkg::OP_IDLE) begin
      tick_d = tick_d + 8'd1;
      if (tick_d >= limit) begin
        case (op_d)
          i2cmbc_pkg::OP_STOP: sda_d = 1'b0;
          i2cmbc_pkg::OP_WRITE: begin
            if (sub_d == 2'd2) shift_d = {shift_d[6:0], 1'b0};
          end
          i2cmbc_pkg::OP_WAIT: begin
            if (phase_d == 5'd1) ack_d = in_item_i.sda_in;
          end
          i2cmbc_pkg::OP_READ: begin
            if (phase_d < i2cmbc_pkg::ReadAckPhase && !phase_d[0]) begin
              shift_d = {shift_d[6:0], in_item_i.sda_in};
              if (phase_d[4:1] == 4'd7) rx_d = shift_d;
            end else if (phase_d == i2cmbc_pkg::ReadLastPhase && mode_d) begin
              sda_d = 1'b0;
            end
          end
          default: begin
          end
        endcase
        tick_d  = 8'd0;
        phase_d = phase_d + 5'd1;
        // Track bit and sub-phase of a write
        if (sub_d == 2'd2) begin
          sub_d = 2'd0;
          bit_d = bit_d + 3'd1;
        end else begin
          sub_d = sub_d + 2'd1;
        end
        if (phase_d >= phase_total(op_d)) begin
          op_d    = i2cmbc_pkg::OP_IDLE;
          phase_d = 5'd0;
          done_d  = 1'b1;
        end else begin
          {scl_d, sda_d} = enter_drive(op_d, phase_d, sub_d, bit_d, shift_d, mode_d,
                                       scl_d, sda_d);
        end
      end
    end

    out_d.scl_drive_low = scl_d;
    out_d.sda_drive_low = sda_d;
    out_d.busy_res      = (op_d != i2cmbc_pkg::OP_IDLE);
    out_d.done_res      = done_d;
    out_d.rx_byte       = rx_d;
    out_d.slave_nack    = ack_d;
  end

  // Hold controller state; advance it on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q    <= i2cmbc_pkg::OP_IDLE;
      phase_q <= 5'd0;
      tick_q  <= 8'd0;
      bit_q   <= 3'd0;
      sub_q   <= 2'd0;
      shift_q <= 8'd0;
      scl_q   <= 1'b0;
      sda_q   <= 1'b0;
      ack_q   <= 1'b1;
      mode_q  <= 1'b0;
      rx_q    <= 8'd0;
    end else if (in_fire) begin
      op_q    <= op_d;
      phase_q <= phase_d;
      tick_q  <= tick_d;
      bit_q   <= bit_d;
      sub_q   <= sub_d;
      shift_q <= shift_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
      ack_q   <= ack_d;
      mode_q  <= mode_d;
      rx_q    <= rx_d;
    end
  end

  // Write the phase length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q <= i2cmbc_pkg::PhaseTicksReset;
    end else if (cfg_valid_i) begin
      ticks_q <= cfg_data_i;
    end
  end

  // Result register: load on accept, drop on take
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ----- rtl/core/i2c_master_byte_controller_checker.sv -----
// Port-level checker for the I2C master byte controller, bound to the controller module.
// Depends on i2cmbc_pkg and i2c_master_byte_controller.
module i2c_master_byte_controller_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input i2cmbc_pkg::out_item_t out_item_o
);

  // Accepted item yields a result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted item gave no result");

  // Input stalls only behind a waiting, untaken result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without back pressure");

  // A finished command leaves the controller free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.done_res |-> !out_item_o.busy_res)
    else $error("done while still busy");

  // Stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

endmodule

bind i2c_master_byte_controller i2c_master_byte_controller_checker u_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_item_o (out_item_o)
);
